@@ rtl/scc_condensation_source_sink_count_top_assert.svh @@
// Assertion macros for the condensation counter checker.
`ifndef SCC_CONDENSATION_SOURCE_SINK_COUNT_TOP_ASSERT_SVH
`define SCC_CONDENSATION_SOURCE_SINK_COUNT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types for the condensation source/sink counter: request and result
// payloads, datapath operation codes, controller command and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int unsigned FieldW = 11;

    typedef struct packed {
        logic [FieldW-1:0] src_vertex;
        logic [FieldW-1:0] dst_vertex;
        logic              edge_present;
        logic              last_edge;
    } t_scc_req;

    typedef struct packed {
        logic [FieldW-1:0] extra_edges_needed;
        logic [FieldW-1:0] component_count;
        logic              edge_overflow;
    } t_scc_rsp;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_LRD,
        OP_LWR,
        OP_INIT,
        OP_VCLR,
        OP_P1RD,
        OP_P1END,
        OP_NEXT,
        OP_START,
        OP_PUSH,
        OP_TOP,
        OP_TOPL,
        OP_ERD,
        OP_ELD,
        OP_VRD,
        OP_CHILD,
        OP_POP,
        OP_WEND,
        OP_P2INIT,
        OP_P2RD,
        OP_P2V,
        OP_IDX0,
        OP_FCLR,
        OP_E0,
        OP_CELD,
        OP_CTRD,
        OP_CCH,
        OP_CCMP,
        OP_CFT,
        OP_CFH,
        OP_CRD,
        OP_CACC,
        OP_EMIT
    } t_scc_op;

    typedef struct packed {
        t_scc_op op;
    } t_scc_cmd;

    typedef struct packed {
        logic last;
        logic rev;
        logic e_ok;
        logic e_end;
        logic w_ok;
        logic vis;
        logic sp_full;
        logic sp_zero;
        logic idx_eq_n;
        logic idx_zero;
        logic idx_last_n;
        logic idx_last_c;
        logic idx_last_v;
        logic idx_eq_c;
        logic th_ok;
        logic diff;
    } t_scc_stat;

endpackage

`default_nettype wire

@@ rtl/scc_ctrl.sv @@
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading, both depth-first passes, the condensation scan
// and the head-list clearing sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire scc_pkg::t_scc_stat i_stat,
    output scc_pkg::t_scc_cmd      o_cmd,
    output logic                   o_busy
);

    typedef enum logic [34:0] {
        S_CLR    = 35'd1 << 0,
        S_IDLE   = 35'd1 << 1,
        S_LRD    = 35'd1 << 2,
        S_LWR    = 35'd1 << 3,
        S_INIT   = 35'd1 << 4,
        S_VCLR   = 35'd1 << 5,
        S_P1     = 35'd1 << 6,
        S_P1CHK  = 35'd1 << 7,
        S_START  = 35'd1 << 8,
        S_PUSH   = 35'd1 << 9,
        S_TOP    = 35'd1 << 10,
        S_TOPL   = 35'd1 << 11,
        S_SCAN   = 35'd1 << 12,
        S_ELD    = 35'd1 << 13,
        S_VRD    = 35'd1 << 14,
        S_VCHK   = 35'd1 << 15,
        S_CHILD  = 35'd1 << 16,
        S_POP    = 35'd1 << 17,
        S_POPCHK = 35'd1 << 18,
        S_WEND   = 35'd1 << 19,
        S_P2INIT = 35'd1 << 20,
        S_P2     = 35'd1 << 21,
        S_P2V    = 35'd1 << 22,
        S_P2CHK  = 35'd1 << 23,
        S_FCLR   = 35'd1 << 24,
        S_E0     = 35'd1 << 25,
        S_CE     = 35'd1 << 26,
        S_CELD   = 35'd1 << 27,
        S_CTH    = 35'd1 << 28,
        S_CCH    = 35'd1 << 29,
        S_CCMP   = 35'd1 << 30,
        S_CFT    = 35'd1 << 31,
        S_CFH    = 35'd1 << 32,
        S_CNT    = 35'd1 << 33,
        S_CACC   = 35'd1 << 34
    } t_state;

    t_state           r_state;
    t_state           n_state;
    scc_pkg::t_scc_op w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_op    = scc_pkg::OP_NONE;
        case (r_state)
            S_CLR: begin
                w_op = scc_pkg::OP_CLR;
                if (i_stat.idx_last_v) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    w_op    = scc_pkg::OP_LATCH;
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                w_op    = scc_pkg::OP_LRD;
                n_state = S_LWR;
            end
            S_LWR: begin
                w_op    = scc_pkg::OP_LWR;
                n_state = i_stat.last ? S_INIT : S_IDLE;
            end
            S_INIT: begin
                w_op    = scc_pkg::OP_INIT;
                n_state = S_VCLR;
            end
            S_VCLR: begin
                w_op = scc_pkg::OP_VCLR;
                if (i_stat.idx_last_n) n_state = i_stat.rev ? S_P2INIT : S_P1;
            end
            S_P1: begin
                if (i_stat.idx_eq_n) begin
                    w_op    = scc_pkg::OP_P1END;
                    n_state = S_VCLR;
                end else begin
                    w_op    = scc_pkg::OP_P1RD;
                    n_state = S_P1CHK;
                end
            end
            S_P1CHK: begin
                if (i_stat.vis) begin
                    w_op    = scc_pkg::OP_NEXT;
                    n_state = S_P1;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                w_op    = scc_pkg::OP_START;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                w_op    = scc_pkg::OP_PUSH;
                n_state = S_TOP;
            end
            S_TOP: begin
                w_op    = scc_pkg::OP_TOP;
                n_state = S_TOPL;
            end
            S_TOPL: begin
                w_op    = scc_pkg::OP_TOPL;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_op    = scc_pkg::OP_ERD;
                n_state = i_stat.e_ok ? S_ELD : S_POP;
            end
            S_ELD: begin
                w_op    = scc_pkg::OP_ELD;
                n_state = S_VRD;
            end
            S_VRD: begin
                if (i_stat.w_ok) begin
                    w_op    = scc_pkg::OP_VRD;
                    n_state = S_VCHK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_VCHK: begin
                if (i_stat.vis) n_state = S_SCAN;
                else if (i_stat.sp_full) n_state = S_POP;
                else n_state = S_CHILD;
            end
            S_CHILD: begin
                w_op    = scc_pkg::OP_CHILD;
                n_state = S_PUSH;
            end
            S_POP: begin
                w_op    = scc_pkg::OP_POP;
                n_state = S_POPCHK;
            end
            S_POPCHK: begin
                n_state = i_stat.sp_zero ? S_WEND : S_TOP;
            end
            S_WEND: begin
                w_op    = scc_pkg::OP_WEND;
                n_state = i_stat.rev ? S_P2 : S_P1;
            end
            S_P2INIT: begin
                w_op    = scc_pkg::OP_P2INIT;
                n_state = S_P2;
            end
            S_P2: begin
                if (i_stat.idx_zero) begin
                    w_op    = scc_pkg::OP_IDX0;
                    n_state = S_FCLR;
                end else begin
                    w_op    = scc_pkg::OP_P2RD;
                    n_state = S_P2V;
                end
            end
            S_P2V: begin
                w_op    = scc_pkg::OP_P2V;
                n_state = S_P2CHK;
            end
            S_P2CHK: begin
                if (i_stat.vis || !i_stat.w_ok) begin
                    w_op    = scc_pkg::OP_NEXT;
                    n_state = S_P2;
                end else begin
                    n_state = S_START;
                end
            end
            S_FCLR: begin
                w_op = scc_pkg::OP_FCLR;
                if (i_stat.idx_last_c) n_state = S_E0;
            end
            S_E0: begin
                w_op    = scc_pkg::OP_E0;
                n_state = S_CE;
            end
            S_CE: begin
                if (i_stat.e_end) begin
                    n_state = S_CNT;
                end else begin
                    w_op    = scc_pkg::OP_ERD;
                    n_state = S_CELD;
                end
            end
            S_CELD: begin
                w_op    = scc_pkg::OP_CELD;
                n_state = S_CTH;
            end
            S_CTH: begin
                if (i_stat.th_ok) begin
                    w_op    = scc_pkg::OP_CTRD;
                    n_state = S_CCH;
                end else begin
                    n_state = S_CE;
                end
            end
            S_CCH: begin
                w_op    = scc_pkg::OP_CCH;
                n_state = S_CCMP;
            end
            S_CCMP: begin
                w_op    = scc_pkg::OP_CCMP;
                n_state = i_stat.diff ? S_CFT : S_CE;
            end
            S_CFT: begin
                w_op    = scc_pkg::OP_CFT;
                n_state = S_CFH;
            end
            S_CFH: begin
                w_op    = scc_pkg::OP_CFH;
                n_state = S_CE;
            end
            S_CNT: begin
                if (i_stat.idx_eq_c) begin
                    w_op    = scc_pkg::OP_EMIT;
                    n_state = S_CLR;
                end else begin
                    w_op    = scc_pkg::OP_CRD;
                    n_state = S_CACC;
                end
            end
            S_CACC: begin
                w_op    = scc_pkg::OP_CACC;
                n_state = S_CNT;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_cmd.op = w_op;
    assign o_busy   = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/scc_dp.sv @@
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: adjacency list memories, walk stack, marks, finish order,
// component labels and flags, counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_dp #(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned MAX_EDGES    = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire scc_pkg::t_scc_cmd  i_cmd,
    input  wire scc_pkg::t_scc_req  i_req,
    input  wire logic [10:0]        i_vertex_count,
    output scc_pkg::t_scc_stat      o_stat,
    output scc_pkg::t_scc_rsp       o_result,
    output logic                    o_result_valid
);

    localparam int unsigned VW   = $clog2(MAX_VERTICES);
    localparam int unsigned NW   = VW + 1;
    localparam int unsigned EW   = $clog2(MAX_EDGES + 1);
    localparam int unsigned EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [NW-1:0] NMAX  = NW'(MAX_VERTICES);
    localparam logic [NW-1:0] NLAST = NW'(MAX_VERTICES - 1);
    localparam logic [EW-1:0] ENULL = EW'(MAX_EDGES);

    scc_pkg::t_scc_op w_op;

    logic [EW-1:0] m_ohead [MAX_VERTICES];
    logic [EW-1:0] m_ihead [MAX_VERTICES];
    logic [EW-1:0] m_onext [MAX_EDGES];
    logic [EW-1:0] m_inext [MAX_EDGES];
    logic [VW-1:0] m_etail [MAX_EDGES];
    logic [VW-1:0] m_ehead [MAX_EDGES];
    logic          m_vis   [MAX_VERTICES];
    logic [VW-1:0] m_fin   [MAX_VERTICES];
    logic [VW-1:0] m_sv    [MAX_VERTICES];
    logic [EW-1:0] m_sl    [MAX_VERTICES];
    logic [VW-1:0] m_comp  [MAX_VERTICES];
    logic [1:0]    m_flag  [MAX_VERTICES];

    logic [EW-1:0] rd_oh, rd_ih, rd_on, rd_in, rd_sl;
    logic [VW-1:0] rd_et, rd_eh, rd_fin, rd_sv, rd_comp;
    logic          rd_vis;
    logic [1:0]    rd_fl;

    scc_pkg::t_scc_req r_item;
    logic [NW-1:0] r_idx, r_sp, r_fin, r_comps, r_n, r_no_in, r_no_out;
    logic [EW-1:0] r_stored, r_e;
    logic          r_ovf, r_rev, r_valid;
    logic [VW-1:0] r_v, r_w, r_t, r_h, r_ct, r_ch;
    scc_pkg::t_scc_rsp r_result;

    logic [VW-1:0]  w_t, w_h, w_s, w_idx, w_idxm1, w_spm1;
    logic           w_ok, w_full, w_add;
    logic [NW-1:0]  w_n, w_best;
    logic [VW-1:0]  a_oh, a_ih, a_vis, a_stk, a_cw, a_cr, a_fw, a_fr;
    logic [EIW-1:0] a_edge;
    logic           we_head, we_vis, we_sl, we_flag;
    logic           wd_vis;
    logic [EW-1:0]  wd_sl;
    logic [1:0]     wd_flag;

    assign w_op    = i_cmd.op;
    assign w_t     = VW'(r_item.src_vertex - 11'd1);
    assign w_h     = VW'(r_item.dst_vertex - 11'd1);
    assign w_idx   = r_idx[VW-1:0];
    assign w_idxm1 = VW'(r_idx - 1'b1);
    assign w_spm1  = VW'(r_sp - 1'b1);
    assign w_s     = r_rev ? r_w : w_idx;
    assign w_ok    = r_item.edge_present
                     && (r_item.src_vertex != '0) && (32'(r_item.src_vertex) <= MAX_VERTICES)
                     && (r_item.dst_vertex != '0) && (32'(r_item.dst_vertex) <= MAX_VERTICES);
    assign w_full  = (r_stored == ENULL);
    assign w_add   = (w_op == scc_pkg::OP_LWR) && w_ok && !w_full;
    assign w_best  = (r_no_in > r_no_out) ? r_no_in : r_no_out;

    always_comb begin
        if (i_vertex_count == '0) w_n = NW'(1);
        else if (32'(i_vertex_count) > MAX_VERTICES) w_n = NMAX;
        else w_n = NW'(i_vertex_count);
    end

    // address and write selection
    always_comb begin
        a_oh    = w_s;
        a_ih    = w_s;
        a_vis   = w_idx;
        a_stk   = w_spm1;
        a_cw    = w_s;
        a_cr    = r_t;
        a_fw    = w_idx;
        a_fr    = w_idx;
        a_edge  = (w_op == scc_pkg::OP_LWR) ? r_stored[EIW-1:0] : r_e[EIW-1:0];
        we_head = 1'b0;
        we_vis  = 1'b0;
        wd_vis  = 1'b0;
        we_sl   = 1'b0;
        wd_sl   = r_e;
        we_flag = 1'b0;
        wd_flag = 2'b00;
        case (w_op)
            scc_pkg::OP_CLR: begin
                a_oh    = w_idx;
                a_ih    = w_idx;
                we_head = 1'b1;
            end
            scc_pkg::OP_LRD: begin
                a_oh = w_t;
                a_ih = w_h;
            end
            scc_pkg::OP_LWR: begin
                a_oh    = w_t;
                a_ih    = w_h;
                we_head = w_add;
            end
            scc_pkg::OP_VCLR: begin
                we_vis = 1'b1;
            end
            scc_pkg::OP_START: begin
                a_vis  = w_s;
                we_vis = 1'b1;
                wd_vis = 1'b1;
            end
            scc_pkg::OP_CHILD: begin
                a_oh   = r_w;
                a_ih   = r_w;
                a_vis  = r_w;
                a_cw   = r_w;
                we_vis = 1'b1;
                wd_vis = 1'b1;
                we_sl  = 1'b1;
            end
            scc_pkg::OP_VRD: begin
                a_vis = r_w;
            end
            scc_pkg::OP_PUSH: begin
                a_stk = r_sp[VW-1:0];
                we_sl = 1'b1;
                wd_sl = r_rev ? rd_ih : rd_oh;
            end
            scc_pkg::OP_P2V: begin
                a_vis = rd_fin;
            end
            scc_pkg::OP_CCH: begin
                a_cr = r_h;
            end
            scc_pkg::OP_FCLR: begin
                we_flag = 1'b1;
            end
            scc_pkg::OP_CCMP: begin
                a_fr = r_ct;
            end
            scc_pkg::OP_CFT: begin
                a_fw    = r_ct;
                a_fr    = r_ch;
                we_flag = 1'b1;
                wd_flag = rd_fl | 2'b10;
            end
            scc_pkg::OP_CFH: begin
                a_fw    = r_ch;
                we_flag = 1'b1;
                wd_flag = rd_fl | 2'b01;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_head) begin
            m_ohead[a_oh] <= (w_op == scc_pkg::OP_CLR) ? ENULL : r_stored;
            m_ihead[a_ih] <= (w_op == scc_pkg::OP_CLR) ? ENULL : r_stored;
        end
        rd_oh <= m_ohead[a_oh];
        rd_ih <= m_ihead[a_ih];
    end

    always_ff @(posedge i_clk) begin
        if (w_add) begin
            m_onext[a_edge] <= rd_oh;
            m_inext[a_edge] <= rd_ih;
            m_etail[a_edge] <= w_t;
            m_ehead[a_edge] <= w_h;
        end
        rd_on <= m_onext[a_edge];
        rd_in <= m_inext[a_edge];
        rd_et <= m_etail[a_edge];
        rd_eh <= m_ehead[a_edge];
    end

    always_ff @(posedge i_clk) begin
        if (we_vis) m_vis[a_vis] <= wd_vis;
        rd_vis <= m_vis[a_vis];
    end

    always_ff @(posedge i_clk) begin
        if ((w_op == scc_pkg::OP_POP) && !r_rev && (r_fin != NMAX)) begin
            m_fin[r_fin[VW-1:0]] <= r_v;
        end
        rd_fin <= m_fin[w_idxm1];
    end

    always_ff @(posedge i_clk) begin
        if (w_op == scc_pkg::OP_PUSH) m_sv[a_stk] <= r_v;
        if (we_sl) m_sl[a_stk] <= wd_sl;
        rd_sv <= m_sv[a_stk];
        rd_sl <= m_sl[a_stk];
    end

    always_ff @(posedge i_clk) begin
        if (r_rev && ((w_op == scc_pkg::OP_START) || (w_op == scc_pkg::OP_CHILD))) begin
            m_comp[a_cw] <= VW'(r_comps);
        end
        rd_comp <= m_comp[a_cr];
    end

    always_ff @(posedge i_clk) begin
        if (we_flag) m_flag[a_fw] <= wd_flag;
        rd_fl <= m_flag[a_fr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_sp     <= '0;
            r_fin    <= '0;
            r_comps  <= '0;
            r_stored <= '0;
            r_ovf    <= 1'b0;
            r_rev    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= (w_op == scc_pkg::OP_EMIT);
            case (w_op)
                scc_pkg::OP_CLR:    r_idx <= r_idx + 1'b1;
                scc_pkg::OP_LWR: begin
                    if (w_add) r_stored <= r_stored + 1'b1;
                    else if (w_ok) r_ovf <= 1'b1;
                end
                scc_pkg::OP_INIT: begin
                    r_fin   <= '0;
                    r_comps <= '0;
                    r_idx   <= '0;
                    r_rev   <= 1'b0;
                end
                scc_pkg::OP_VCLR:   r_idx <= o_stat.idx_last_n ? '0 : r_idx + 1'b1;
                scc_pkg::OP_P1END: begin
                    r_idx <= '0;
                    r_rev <= 1'b1;
                end
                scc_pkg::OP_NEXT:   r_idx <= r_rev ? r_idx - 1'b1 : r_idx + 1'b1;
                scc_pkg::OP_WEND: begin
                    r_idx <= r_rev ? r_idx - 1'b1 : r_idx + 1'b1;
                    if (r_rev) r_comps <= r_comps + 1'b1;
                end
                scc_pkg::OP_START:  r_sp <= '0;
                scc_pkg::OP_PUSH:   r_sp <= r_sp + 1'b1;
                scc_pkg::OP_POP: begin
                    r_sp <= r_sp - 1'b1;
                    if (!r_rev && (r_fin != NMAX)) r_fin <= r_fin + 1'b1;
                end
                scc_pkg::OP_P2INIT: r_idx <= r_fin;
                scc_pkg::OP_IDX0:   r_idx <= '0;
                scc_pkg::OP_FCLR:   r_idx <= o_stat.idx_last_c ? '0 : r_idx + 1'b1;
                scc_pkg::OP_E0:     r_idx <= '0;
                scc_pkg::OP_CACC:   r_idx <= r_idx + 1'b1;
                scc_pkg::OP_EMIT: begin
                    r_idx    <= '0;
                    r_stored <= '0;
                    r_ovf    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_op)
            scc_pkg::OP_LATCH: r_item <= i_req;
            scc_pkg::OP_INIT: begin
                r_n      <= w_n;
                r_no_in  <= '0;
                r_no_out <= '0;
            end
            scc_pkg::OP_START: r_v <= w_s;
            scc_pkg::OP_TOPL: begin
                r_v <= rd_sv;
                r_e <= rd_sl;
            end
            scc_pkg::OP_ELD: begin
                r_w <= r_rev ? rd_et : rd_eh;
                r_e <= r_rev ? rd_in : rd_on;
            end
            scc_pkg::OP_CHILD: r_v <= r_w;
            scc_pkg::OP_P2V:   r_w <= rd_fin;
            scc_pkg::OP_E0:    r_e <= '0;
            scc_pkg::OP_CELD: begin
                r_t <= rd_et;
                r_h <= rd_eh;
                r_e <= r_e + 1'b1;
            end
            scc_pkg::OP_CCH:  r_ct <= rd_comp;
            scc_pkg::OP_CCMP: r_ch <= rd_comp;
            scc_pkg::OP_CACC: begin
                r_no_in  <= r_no_in + NW'(!rd_fl[0]);
                r_no_out <= r_no_out + NW'(!rd_fl[1]);
            end
            scc_pkg::OP_EMIT: begin
                r_result.extra_edges_needed <= 11'(w_best);
                r_result.component_count    <= 11'(r_comps);
                r_result.edge_overflow      <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.last       = r_item.last_edge;
    assign o_stat.rev        = r_rev;
    assign o_stat.e_ok       = (r_e < r_stored);
    assign o_stat.e_end      = (r_e == r_stored);
    assign o_stat.w_ok       = ({1'b0, r_w} < r_n);
    assign o_stat.vis        = rd_vis;
    assign o_stat.sp_full    = (r_sp == NMAX);
    assign o_stat.sp_zero    = (r_sp == '0);
    assign o_stat.idx_eq_n   = (r_idx == r_n);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.idx_last_n = (r_idx == r_n - 1'b1);
    assign o_stat.idx_last_c = (r_idx == r_comps - 1'b1);
    assign o_stat.idx_last_v = (r_idx == NLAST);
    assign o_stat.idx_eq_c   = (r_idx == r_comps);
    assign o_stat.th_ok      = ({1'b0, r_t} < r_n) && ({1'b0, r_h} < r_n);
    assign o_stat.diff       = (r_ct != rd_comp);

    assign o_result       = r_result;
    assign o_result_valid = r_valid;

endmodule

`default_nettype wire

@@ rtl/scc_condensation_source_sink_count_top.sv @@
// ----------------------------------------------------------------------------
// scc_condensation_source_sink_count_top
// Counts strongly connected components of a directed graph and the larger of
// the source and sink component counts of its condensation.
//
// Request channel: i_start with i_req, taken when o_busy is low. Each request
// carries at most one edge; one with last_edge set starts the computation.
// Each edge request reads the list heads and then links the edge.
// After the last request the block runs two depth-first passes and a scan of
// all edges; the time grows with vertices plus edges, set by the single-port
// list, mark and label memories.
// The result shows on o_result for one cycle with o_result_valid; the
// receiver cannot stall it. A clearing sweep over all MAX_VERTICES list heads
// begins with it and resets them while o_busy stays high.
// After reset the same sweep runs before the first request is taken.
// vertex_count sits at APB address 0 and resets to 1; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_condensation_source_sink_count_top #(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned MAX_EDGES    = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire scc_pkg::t_scc_req i_req,
    output logic                   o_busy,
    output scc_pkg::t_scc_rsp      o_result,
    output logic                   o_result_valid,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [10:0]         r_vertex_count;
    scc_pkg::t_scc_cmd   w_cmd;
    scc_pkg::t_scc_stat  w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= 11'd1;
        end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
            r_vertex_count <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(r_vertex_count) : 32'd0;

    scc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    scc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req          (i_req),
        .i_vertex_count (r_vertex_count),
        .o_stat         (w_stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire

@@ rtl/scc_checker.sv @@
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks on request acceptance, result timing and result counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scc_condensation_source_sink_count_top_assert.svh"

module scc_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic              o_result_valid,
    input wire scc_pkg::t_scc_rsp o_result
);

    `SCC_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "accepted request left block idle")
    `SCC_ASSERT_NOW(a_result_busy, o_result_valid, o_busy, "result while idle")
    `SCC_ASSERT_NEXT(a_result_pulse, o_result_valid, !o_result_valid && o_busy, "result not one pulse before clear")
    `SCC_ASSERT_NOW(a_result_range, o_result_valid, (o_result.component_count != 11'd0) && (o_result.extra_edges_needed <= o_result.component_count), "result counts inconsistent")

endmodule

bind scc_condensation_source_sink_count_top scc_checker u_scc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
